/* hw/rtl/aae_pkg.sv */
// adaptive arithmetic encoder: shared types, constants and default-model functions
// no dependencies; imported by every module of the block
package aae_pkg;

    localparam int MAX_SYMBOLS  = 16;
    localparam int MAX_CONTEXTS = 8;
    localparam int FREQ_LIMIT   = 16383;
    localparam int FREQ_W       = 14;
    localparam int SYM_W        = 5;
    localparam int CTX_CNT_W    = 4;
    localparam int WORD_W       = 4;
    localparam int CTX_W        = 3;
    localparam int ROW          = MAX_SYMBOLS + 2;
    localparam int RANK_W       = $clog2(ROW);
    localparam int STEP_CAP     = 16;
    localparam int STEP_W       = $clog2(STEP_CAP + 1);
    localparam int FOLLOW_W     = 16;

    localparam logic [1:0] MODE_CODE   = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    localparam logic REG_SYMBOL_COUNT  = 1'b0;
    localparam logic REG_CONTEXT_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [WORD_W-1:0] word;
        logic [CTX_W-1:0]  context_req;
        logic              adapt;
    } in_item_t;

    typedef struct packed {
        logic                has_bit;
        logic                code_bit;
        logic [FOLLOW_W-1:0] follow_count;
        logic                last;
        logic                error;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_CODE,
        OP_FINISH,
        OP_START,
        OP_SKIP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              err;
        logic [WORD_W-1:0] word;
        logic [CTX_W-1:0]  ctx;
        logic              adapt;
        logic [SYM_W-1:0]  n_syms;
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0] f;
        logic [FREQ_W-1:0] cm;
    } fc_t;

    // uniform model: count 1 at ranks 1..n
    function automatic logic [FREQ_W-1:0] dflt_f(input logic [RANK_W-1:0] k,
                                                 input logic [SYM_W-1:0] n);
        dflt_f = (k != '0 && k <= RANK_W'(n)) ? FREQ_W'(1) : '0;
    endfunction

    // uniform model: cumulative count n-k up to rank n
    function automatic logic [FREQ_W-1:0] dflt_cm(input logic [RANK_W-1:0] k,
                                                  input logic [SYM_W-1:0] n);
        dflt_cm = (k <= RANK_W'(n)) ? FREQ_W'(RANK_W'(n) - k) : '0;
    endfunction

endpackage

/* hw/rtl/aae_front.sv */
// adaptive arithmetic encoder: input stage, checks and classifies each item
// depends on aae_pkg
module aae_front import aae_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    input  logic [SYM_W-1:0]     symbol_count,
    input  logic [CTX_CNT_W-1:0] context_count,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic [SYM_W-1:0]     act_syms_reg;
    logic [CTX_CNT_W-1:0] act_ctxs_reg;
    logic [SYM_W-1:0]     syms_clamp;
    logic [CTX_CNT_W-1:0] ctxs_clamp;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;

    always_comb begin
        if (symbol_count == '0) begin
            syms_clamp = SYM_W'(1);
        end else if (symbol_count > SYM_W'(MAX_SYMBOLS)) begin
            syms_clamp = SYM_W'(MAX_SYMBOLS);
        end else begin
            syms_clamp = symbol_count;
        end
        if (context_count == '0) begin
            ctxs_clamp = CTX_CNT_W'(1);
        end else if (context_count > CTX_CNT_W'(MAX_CONTEXTS)) begin
            ctxs_clamp = CTX_CNT_W'(MAX_CONTEXTS);
        end else begin
            ctxs_clamp = context_count;
        end
    end

    always_comb begin
        cmd.word   = s_data.word;
        cmd.ctx    = s_data.context_req;
        cmd.adapt  = s_data.adapt;
        cmd.n_syms = act_syms_reg;
        cmd.err    = 1'b0;
        case (s_data.mode)
            MODE_CODE: begin
                cmd.op = OP_CODE;
                if ({1'b0, s_data.word} >= act_syms_reg ||
                    {1'b0, s_data.context_req} >= act_ctxs_reg) begin
                    cmd.op  = OP_SKIP;
                    cmd.err = 1'b1;
                end
            end
            MODE_FINISH: cmd.op = OP_FINISH;
            MODE_START:  cmd.op = OP_START;
            default:     cmd.op = OP_SKIP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_syms_reg <= SYM_W'(2);
            act_ctxs_reg <= CTX_CNT_W'(5);
        end else if (s_valid && s_ready && s_data.mode == MODE_START) begin
            act_syms_reg <= syms_clamp;
            act_ctxs_reg <= ctxs_clamp;
        end
    end

endmodule

/* hw/rtl/aae_queue.sv */
// adaptive arithmetic encoder: two-entry command queue between front and back
// depends on aae_pkg
module aae_queue import aae_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/aae_back.sv */
// adaptive arithmetic encoder: coding sequencer, context model memories, result register
// depends on aae_pkg
module aae_back import aae_pkg::*; #(
    parameter int CODE_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int RNG_W  = CODE_BITS + 1;
    localparam int PROD_W = RNG_W + FREQ_W;
    localparam int CNT_W  = $clog2(RNG_W + 1);
    localparam int ADDR_W = CTX_W + RANK_W;
    localparam int W2R_W  = CTX_W + WORD_W;
    localparam logic [CODE_BITS-1:0] TOP  = '1;
    localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTR1 = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] QTR3 = HALF | QTR1;

    typedef enum logic [25:0] {
        ST_IDLE    = 26'd1 << 0,
        ST_FILL    = 26'd1 << 1,
        ST_RANK    = 26'd1 << 2,
        ST_CUMA    = 26'd1 << 3,
        ST_CUMB    = 26'd1 << 4,
        ST_MULA    = 26'd1 << 5,
        ST_DIVA    = 26'd1 << 6,
        ST_MULB    = 26'd1 << 7,
        ST_DIVB    = 26'd1 << 8,
        ST_SETLO   = 26'd1 << 9,
        ST_NORM    = 26'd1 << 10,
        ST_AD_RD   = 26'd1 << 11,
        ST_AD_CHK  = 26'd1 << 12,
        ST_SC_RD   = 26'd1 << 13,
        ST_SC_WR   = 26'd1 << 14,
        ST_SRCH    = 26'd1 << 15,
        ST_SRCH_Q  = 26'd1 << 16,
        ST_WALK_RD = 26'd1 << 17,
        ST_WALK_Q  = 26'd1 << 18,
        ST_SW_RD   = 26'd1 << 19,
        ST_SW_Q    = 26'd1 << 20,
        ST_SW_WR   = 26'd1 << 21,
        ST_SW_WR2  = 26'd1 << 22,
        ST_INC_RD  = 26'd1 << 23,
        ST_INC_WR  = 26'd1 << 24,
        ST_END     = 26'd1 << 25
    } state_t;

    state_t                  state_reg;
    cmd_t                    cmd_reg;
    logic [CODE_BITS-1:0]    low_reg;
    logic [CODE_BITS-1:0]    high_reg;
    logic [CODE_BITS-1:0]    hi_tmp_reg;
    logic [FOLLOW_W-1:0]     pend_reg;
    logic [MAX_CONTEXTS-1:0] valid_reg;
    logic [RANK_W-1:0]       r_reg;
    logic [RANK_W-1:0]       i_reg;
    logic [RANK_W-1:0]       k_reg;
    logic [FREQ_W-1:0]       tot_reg;
    logic [FREQ_W-1:0]       cuma_reg;
    logic [FREQ_W-1:0]       cumb_reg;
    logic [FREQ_W-1:0]       fr_reg;
    logic [FREQ_W:0]         cum_reg;
    logic [FREQ_W-1:0]       rem_reg;
    logic [RNG_W-1:0]        dvd_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [WORD_W-1:0]       wi_reg;
    logic [WORD_W-1:0]       wr_reg;
    logic                    stg_valid_reg;
    out_item_t               stg_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    fc_t                     fc_mem  [MAX_CONTEXTS << RANK_W];
    logic [WORD_W-1:0]       r2w_mem [MAX_CONTEXTS << RANK_W];
    logic [RANK_W-1:0]       w2r_mem [MAX_CONTEXTS << WORD_W];
    fc_t                     fc_q;
    logic [WORD_W-1:0]       r2w_q;
    logic [RANK_W-1:0]       w2r_q;
    logic                    fc_we, r2w_we, w2r_we;
    logic [ADDR_W-1:0]       fc_raddr, fc_waddr, r2w_raddr, r2w_waddr;
    logic [W2R_W-1:0]        w2r_raddr, w2r_waddr;
    fc_t                     fc_wdata;
    logic [WORD_W-1:0]       r2w_wdata;
    logic [RANK_W-1:0]       w2r_wdata;

    logic                    dflt;
    logic [SYM_W-1:0]        n;
    logic                    slot_free;
    logic                    can_emit;
    logic                    m_load;
    logic [RNG_W-1:0]        range;
    logic [FREQ_W-1:0]       mul_b;
    logic [PROD_W-1:0]       prod;
    logic [FREQ_W:0]         div_t;
    logic                    div_ge;
    logic [FREQ_W-1:0]       rem_step;
    logic [RNG_W-1:0]        hi_sum;
    logic [RNG_W-1:0]        lo_sum;
    logic [RANK_W-1:0]       rank_raw;
    logic [RANK_W-1:0]       r_clip;
    logic [FREQ_W-1:0]       tot_c;
    logic [FREQ_W-1:0]       f_half;
    logic [FOLLOW_W-1:0]     fol_inc;
    logic [CODE_BITS-1:0]    low_q;
    logic [CODE_BITS-1:0]    high_q;
    out_item_t               new_res;
    out_item_t               end_res;
    out_item_t               fin_res;

    assign cmd_ready = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign dflt      = !valid_reg[cmd_reg.ctx];
    assign n         = cmd_reg.n_syms;
    assign slot_free = !m_valid_reg || m_ready;
    assign can_emit  = !stg_valid_reg || slot_free;
    assign range     = {1'b0, high_reg} - {1'b0, low_reg} + RNG_W'(1);
    assign mul_b     = (state_reg == ST_MULA) ? cuma_reg : cumb_reg;
    assign prod      = range * mul_b;
    assign div_t     = {rem_reg, dvd_reg[RNG_W-1]};
    assign div_ge    = div_t >= {1'b0, tot_reg};
    assign rem_step  = div_ge ? FREQ_W'(div_t - {1'b0, tot_reg}) : div_t[FREQ_W-1:0];
    assign hi_sum    = {1'b0, low_reg} + dvd_reg - RNG_W'(1);
    assign lo_sum    = {1'b0, low_reg} + dvd_reg;
    assign f_half    = FREQ_W'(({1'b0, fc_q.f} + (FREQ_W + 1)'(1)) >> 1);
    assign fol_inc   = (pend_reg == '1) ? pend_reg : pend_reg + FOLLOW_W'(1);
    assign low_q     = low_reg - QTR1;
    assign high_q    = high_reg - QTR1;

    // output register loads on the end of a command or when a staged bit is pushed out
    assign m_load = (state_reg == ST_END && slot_free) ||
                    (state_reg == ST_NORM && step_reg != STEP_W'(STEP_CAP) &&
                     (high_reg < HALF || low_reg >= HALF) && can_emit && stg_valid_reg);

    always_comb begin
        rank_raw = dflt ? RANK_W'({1'b0, cmd_reg.word}) + RANK_W'(1) : w2r_q;
        if (rank_raw == '0) begin
            r_clip = RANK_W'(1);
        end else if (rank_raw > RANK_W'(n)) begin
            r_clip = RANK_W'(n);
        end else begin
            r_clip = rank_raw;
        end
        tot_c = dflt ? FREQ_W'(n) : fc_q.cm;
        if (tot_c == '0) begin
            tot_c = FREQ_W'(1);
        end
    end

    always_comb begin
        new_res              = '0;
        new_res.has_bit      = 1'b1;
        new_res.code_bit     = !(high_reg < HALF);
        new_res.follow_count = pend_reg;
        fin_res              = '0;
        fin_res.has_bit      = 1'b1;
        fin_res.code_bit     = !(low_reg < QTR1);
        fin_res.follow_count = fol_inc;
        end_res              = '0;
        end_res.last         = 1'b1;
        end_res.error        = cmd_reg.err;
        if (stg_valid_reg) begin
            end_res      = stg_reg;
            end_res.last = 1'b1;
        end
    end

    // memory port control
    always_comb begin
        fc_we     = 1'b0;
        r2w_we    = 1'b0;
        w2r_we    = 1'b0;
        fc_raddr  = {cmd_reg.ctx, RANK_W'(0)};
        fc_waddr  = {cmd_reg.ctx, k_reg};
        fc_wdata  = fc_q;
        r2w_raddr = {cmd_reg.ctx, i_reg};
        r2w_waddr = {cmd_reg.ctx, k_reg};
        r2w_wdata = '0;
        w2r_raddr = {cmd_reg.ctx, cmd_reg.word};
        w2r_waddr = {cmd_reg.ctx, k_reg[WORD_W-1:0]};
        w2r_wdata = k_reg + RANK_W'(1);
        case (state_reg)
            ST_FILL: begin
                fc_we         = 1'b1;
                fc_wdata.f    = dflt_f(k_reg, n);
                fc_wdata.cm   = dflt_cm(k_reg, n);
                r2w_we        = 1'b1;
                if (k_reg != '0 && k_reg <= RANK_W'(MAX_SYMBOLS)) begin
                    r2w_wdata = WORD_W'(k_reg - RANK_W'(1));
                end
                w2r_we        = k_reg < RANK_W'(MAX_SYMBOLS);
            end
            ST_CUMA:    fc_raddr = {cmd_reg.ctx, r_clip - RANK_W'(1)};
            ST_CUMB:    fc_raddr = {cmd_reg.ctx, r_reg};
            ST_SC_RD:   fc_raddr = {cmd_reg.ctx, k_reg};
            ST_SC_WR: begin
                fc_we       = 1'b1;
                fc_wdata.f  = f_half;
                fc_wdata.cm = cum_reg[FREQ_W-1:0];
            end
            ST_SRCH:    fc_raddr = {cmd_reg.ctx, r_reg};
            ST_WALK_RD: fc_raddr = {cmd_reg.ctx, i_reg - RANK_W'(1)};
            ST_SW_Q:    r2w_raddr = {cmd_reg.ctx, r_reg};
            ST_SW_WR: begin
                r2w_we    = 1'b1;
                r2w_waddr = {cmd_reg.ctx, i_reg};
                r2w_wdata = r2w_q;
                w2r_we    = 1'b1;
                w2r_waddr = {cmd_reg.ctx, wi_reg};
                w2r_wdata = r_reg;
            end
            ST_SW_WR2: begin
                r2w_we    = 1'b1;
                r2w_waddr = {cmd_reg.ctx, r_reg};
                r2w_wdata = wi_reg;
                w2r_we    = 1'b1;
                w2r_waddr = {cmd_reg.ctx, wr_reg};
                w2r_wdata = i_reg;
            end
            ST_INC_RD:  fc_raddr = {cmd_reg.ctx, k_reg};
            ST_INC_WR: begin
                fc_we = 1'b1;
                if (k_reg == i_reg) begin
                    fc_wdata.f = fc_q.f + FREQ_W'(1);
                end else begin
                    fc_wdata.cm = fc_q.cm + FREQ_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fc_we) begin
            fc_mem[fc_waddr] <= fc_wdata;
        end
        fc_q <= fc_mem[fc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (r2w_we) begin
            r2w_mem[r2w_waddr] <= r2w_wdata;
        end
        r2w_q <= r2w_mem[r2w_raddr];
    end

    always_ff @(posedge aclk) begin
        if (w2r_we) begin
            w2r_mem[w2r_waddr] <= w2r_wdata;
        end
        w2r_q <= w2r_mem[w2r_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            low_reg       <= '0;
            high_reg      <= TOP;
            pend_reg      <= '0;
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg <= cmd;
                        k_reg   <= '0;
                        case (cmd.op)
                            OP_CODE: begin
                                if (cmd.adapt && !valid_reg[cmd.ctx]) begin
                                    state_reg <= ST_FILL;
                                end else begin
                                    state_reg <= ST_RANK;
                                end
                            end
                            OP_FINISH: begin
                                stg_valid_reg <= 1'b1;
                                stg_reg       <= fin_res;
                                low_reg       <= '0;
                                high_reg      <= TOP;
                                pend_reg      <= '0;
                                state_reg     <= ST_END;
                            end
                            OP_START: begin
                                valid_reg <= '0;
                                low_reg   <= '0;
                                high_reg  <= TOP;
                                pend_reg  <= '0;
                                state_reg <= ST_END;
                            end
                            default: state_reg <= ST_END;
                        endcase
                    end
                end
                ST_FILL: begin
                    if (k_reg == RANK_W'(ROW - 1)) begin
                        valid_reg[cmd_reg.ctx] <= 1'b1;
                        state_reg              <= ST_RANK;
                    end else begin
                        k_reg <= k_reg + RANK_W'(1);
                    end
                end
                ST_RANK: state_reg <= ST_CUMA;
                ST_CUMA: begin
                    r_reg     <= r_clip;
                    tot_reg   <= tot_c;
                    state_reg <= ST_CUMB;
                end
                ST_CUMB: begin
                    cuma_reg  <= dflt ? dflt_cm(r_reg - RANK_W'(1), n) : fc_q.cm;
                    state_reg <= ST_MULA;
                end
                ST_MULA: begin
                    cumb_reg  <= dflt ? dflt_cm(r_reg, n) : fc_q.cm;
                    rem_reg   <= prod[PROD_W-1:RNG_W];
                    dvd_reg   <= prod[RNG_W-1:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVA;
                end
                ST_DIVA, ST_DIVB: begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[RNG_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(RNG_W - 1)) begin
                        state_reg <= (state_reg == ST_DIVA) ? ST_MULB : ST_SETLO;
                    end
                end
                ST_MULB: begin
                    hi_tmp_reg <= hi_sum[CODE_BITS-1:0];
                    rem_reg    <= prod[PROD_W-1:RNG_W];
                    dvd_reg    <= prod[RNG_W-1:0];
                    cnt_reg    <= '0;
                    state_reg  <= ST_DIVB;
                end
                ST_SETLO: begin
                    low_reg   <= lo_sum[CODE_BITS-1:0];
                    high_reg  <= hi_tmp_reg;
                    step_reg  <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    if (step_reg == STEP_W'(STEP_CAP)) begin
                        state_reg <= cmd_reg.adapt ? ST_AD_RD : ST_END;
                    end else if (high_reg < HALF || low_reg >= HALF) begin
                        if (can_emit) begin
                            if (stg_valid_reg) begin
                                m_data_reg <= stg_reg;
                            end
                            stg_valid_reg <= 1'b1;
                            stg_reg       <= new_res;
                            pend_reg      <= '0;
                            low_reg       <= {low_reg[CODE_BITS-2:0], 1'b0};
                            high_reg      <= {high_reg[CODE_BITS-2:0], 1'b1};
                            step_reg      <= step_reg + STEP_W'(1);
                        end
                    end else if (low_reg >= QTR1 && high_reg < QTR3) begin
                        pend_reg <= fol_inc;
                        low_reg  <= {low_q[CODE_BITS-2:0], 1'b0};
                        high_reg <= {high_q[CODE_BITS-2:0], 1'b1};
                        step_reg <= step_reg + STEP_W'(1);
                    end else begin
                        state_reg <= cmd_reg.adapt ? ST_AD_RD : ST_END;
                    end
                end
                ST_AD_RD: state_reg <= ST_AD_CHK;
                ST_AD_CHK: begin
                    r_reg <= w2r_q;
                    if (fc_q.cm >= FREQ_W'(FREQ_LIMIT)) begin
                        k_reg     <= RANK_W'(n) + RANK_W'(1);
                        cum_reg   <= '0;
                        state_reg <= ST_SC_RD;
                    end else begin
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SC_RD: state_reg <= ST_SC_WR;
                ST_SC_WR: begin
                    cum_reg <= cum_reg + (FREQ_W + 1)'(f_half);
                    if (k_reg == '0) begin
                        state_reg <= ST_SRCH;
                    end else begin
                        k_reg     <= k_reg - RANK_W'(1);
                        state_reg <= ST_SC_RD;
                    end
                end
                ST_SRCH: state_reg <= ST_SRCH_Q;
                ST_SRCH_Q: begin
                    fr_reg    <= fc_q.f;
                    i_reg     <= r_reg;
                    state_reg <= ST_WALK_RD;
                end
                ST_WALK_RD: begin
                    if (i_reg == '0) begin
                        i_reg     <= RANK_W'(1);
                        k_reg     <= RANK_W'(1);
                        state_reg <= (RANK_W'(1) < r_reg) ? ST_SW_RD : ST_INC_RD;
                    end else begin
                        state_reg <= ST_WALK_Q;
                    end
                end
                ST_WALK_Q: begin
                    if (fc_q.f == fr_reg) begin
                        i_reg     <= i_reg - RANK_W'(1);
                        state_reg <= ST_WALK_RD;
                    end else begin
                        k_reg     <= i_reg;
                        state_reg <= (i_reg < r_reg) ? ST_SW_RD : ST_INC_RD;
                    end
                end
                ST_SW_RD: state_reg <= ST_SW_Q;
                ST_SW_Q: begin
                    wi_reg    <= r2w_q;
                    state_reg <= ST_SW_WR;
                end
                ST_SW_WR: begin
                    wr_reg    <= r2w_q;
                    state_reg <= ST_SW_WR2;
                end
                ST_SW_WR2: state_reg <= ST_INC_RD;
                ST_INC_RD: state_reg <= ST_INC_WR;
                ST_INC_WR: begin
                    if (k_reg == '0) begin
                        state_reg <= ST_END;
                    end else begin
                        k_reg     <= k_reg - RANK_W'(1);
                        state_reg <= ST_INC_RD;
                    end
                end
                ST_END: begin
                    if (slot_free) begin
                        m_data_reg    <= end_res;
                        stg_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/adaptive_arith_encoder.sv */
// adaptive arithmetic encoder: top level with configuration registers
// depends on aae_pkg, aae_front, aae_queue, aae_back
//
// Multi-context adaptive arithmetic encoder. Each input transfer is a
// command: code a word in a context (optionally adapting that context's
// model), finish (flush one bit plus pending follow bits), or start (reset
// every context to a uniform model over symbol_count words and reopen the
// interval). Every emitted bit leaves as one result transfer carrying the bit
// and its follow count; the final result of a command has last set, and a
// command that emits nothing gives one empty result. Out-of-range words or
// contexts give one empty result with error set. symbol_count and
// context_count are taken at the next start. A code command's time is set
// by the bit-serial divider, which runs twice, plus the renormalization
// steps; adapting adds time per rank walked, per cumulative count
// incremented, per entry when counts are halved, and to load a context row
// on its first adapt after a start. Commands are processed one at a time;
// the front stage and a two-entry queue keep accepting while the back end
// works, until the queue is full.
module adaptive_arith_encoder import aae_pkg::*; #(
    parameter int CODE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input command channel
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SYM_W-1:0]     symbol_count_reg;
    logic [CTX_CNT_W-1:0] context_count_reg;

    // front to queue, queue to back
    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    // apb: zero wait states, register index in paddr[2]
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_SYMBOL_COUNT:  prdata = {{(32 - SYM_W){1'b0}}, symbol_count_reg};
            REG_CONTEXT_COUNT: prdata = {{(32 - CTX_CNT_W){1'b0}}, context_count_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg  <= SYM_W'(2);
            context_count_reg <= CTX_CNT_W'(5);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_SYMBOL_COUNT:  symbol_count_reg  <= pwdata[SYM_W-1:0];
                REG_CONTEXT_COUNT: context_count_reg <= pwdata[CTX_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // classify commands against the active counts
    aae_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .symbol_count  (symbol_count_reg),
        .context_count (context_count_reg),
        .cmd_valid     (fq_valid),
        .cmd_ready     (fq_ready),
        .cmd           (fq_cmd)
    );

    // decouples classification from the coding sequencer
    aae_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // interval arithmetic, renormalization, model adaptation
    aae_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* hw/rtl/aae_checker.sv */
// adaptive arithmetic encoder: port-level assertions and bind to the top level
// depends on aae_pkg, adaptive_arith_encoder
module aae_checker import aae_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_bit |-> !m_data.code_bit && m_data.follow_count == '0)
        else $error("empty result carries bit data");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.last && !m_data.has_bit)
        else $error("error result not a single empty result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind adaptive_arith_encoder aae_checker u_aae_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
